// ===== hw/rtl/tpid_pkg.sv =====
// Shared types, codes and defaults for the two-plane image packet deframer.
package tpid_pkg;

   localparam int PLANE_BYTES_DEFAULT = 640 * 384 / 8;
   localparam int PLANE_BYTES_MAX     = 32768;

   localparam int BYTE_W   = 8;
   localparam int FLEN_W   = 17;
   localparam int PLEN_W   = 16;
   localparam int WADDR_W  = 15;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] SYNC_DEFAULT      = 8'hAA;
   localparam logic [BYTE_W-1:0] END_MARK_DEFAULT  = 8'hFF;
   localparam logic [BYTE_W-1:0] RED_TYPE_DEFAULT  = 8'h14;
   localparam logic [BYTE_W-1:0] MONO_TYPE_DEFAULT = 8'h25;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_TYPE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MONO_TYPE = 2'd3;

   // frame status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SYNC = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_LEN_MISS = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TYPE = 3'd4;

   // header byte positions
   localparam logic [FLEN_W-1:0] POS_SYNC     = 17'd0;
   localparam logic [FLEN_W-1:0] POS_END_MARK = 17'd1;
   localparam logic [FLEN_W-1:0] POS_TYPE     = 17'd2;
   localparam logic [FLEN_W-1:0] POS_LEN_HI   = 17'd3;
   localparam logic [FLEN_W-1:0] POS_LEN_LO   = 17'd4;
   localparam logic [FLEN_W-1:0] HDR_BYTES    = 17'd5;
   localparam logic [FLEN_W-1:0] POS_MAX      = 17'h1FFFF;

   localparam logic PLANE_RED  = 1'b0;
   localparam logic PLANE_MONO = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_value;
      logic [BYTE_W-1:0] end_marker;
      logic [BYTE_W-1:0] red_type_code;
      logic [BYTE_W-1:0] mono_type_code;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic [FLEN_W-1:0] frame_len;
      logic              frame_last;
   } item_type;

   typedef struct packed {
      logic [FLEN_W-1:0]   byte_position;
      logic                frame_end_flag;
      logic                frame_plane;
      logic [PLEN_W-1:0]   payload_length;
      logic [STATUS_W-1:0] frame_error;
   } frame_type;

   typedef struct packed {
      logic                write_valid;
      logic                plane_sel;
      logic [WADDR_W-1:0]  write_addr;
      logic [BYTE_W-1:0]   write_data;
      logic                image_done;
      logic [STATUS_W-1:0] frame_status;
   } result_type;

endpackage

// ===== hw/rtl/tpid_frame_step.sv =====
// Per-byte frame parse: next frame state, plane addresses and the result item.
module tpid_frame_step #(
   parameter int PLANE_BYTES = tpid_pkg::PLANE_BYTES_DEFAULT
) (
   input  tpid_pkg::cfg_type               cfg,
   input  tpid_pkg::item_type              item,
   input  tpid_pkg::frame_type             frm,
   input  logic [$clog2(PLANE_BYTES+1)-1:0] red_addr,
   input  logic [$clog2(PLANE_BYTES+1)-1:0] mono_addr,
   output tpid_pkg::frame_type             frm_next,
   output logic [$clog2(PLANE_BYTES+1)-1:0] red_addr_next,
   output logic [$clog2(PLANE_BYTES+1)-1:0] mono_addr_next,
   output tpid_pkg::result_type            res
);

   localparam int AW = $clog2(PLANE_BYTES + 1);
   localparam logic [AW-1:0] ADDR_LIMIT = AW'(PLANE_BYTES);

   logic [tpid_pkg::FLEN_W-1:0] pos;
   logic [tpid_pkg::FLEN_W-1:0] payload_end;
   logic [AW-1:0]               cur_addr;
   logic [AW-1:0]               cur_addr_inc;
   logic [tpid_pkg::STATUS_W-1:0] status;

   always_comb begin
      pos          = frm.byte_position;
      frm_next     = frm;
      red_addr_next  = red_addr;
      mono_addr_next = mono_addr;
      res          = '0;
      status       = tpid_pkg::STATUS_OK;
      payload_end  = tpid_pkg::HDR_BYTES + tpid_pkg::FLEN_W'(frm.payload_length);
      cur_addr     = (frm.frame_plane == tpid_pkg::PLANE_MONO) ? mono_addr : red_addr;
      cur_addr_inc = cur_addr + AW'(1);

      if (pos == tpid_pkg::POS_SYNC) begin
         frm_next.frame_end_flag = 1'b0;
         frm_next.frame_plane    = tpid_pkg::PLANE_RED;
         frm_next.payload_length = '0;
         if (item.frame_len < tpid_pkg::HDR_BYTES) begin
            frm_next.frame_error = tpid_pkg::STATUS_SHORT;
         end else if (item.rx_byte != cfg.sync_value) begin
            frm_next.frame_error = tpid_pkg::STATUS_BAD_SYNC;
         end else begin
            frm_next.frame_error = tpid_pkg::STATUS_OK;
         end
      end else if (pos == tpid_pkg::POS_END_MARK) begin
         frm_next.frame_end_flag = (item.rx_byte == cfg.end_marker);
      end else if (pos == tpid_pkg::POS_TYPE) begin
         if (frm.frame_error == tpid_pkg::STATUS_OK) begin
            // red wins when both codes match
            if (item.rx_byte == cfg.red_type_code) begin
               frm_next.frame_plane = tpid_pkg::PLANE_RED;
            end else if (item.rx_byte == cfg.mono_type_code) begin
               frm_next.frame_plane = tpid_pkg::PLANE_MONO;
            end else begin
               frm_next.frame_error = tpid_pkg::STATUS_BAD_TYPE;
            end
         end
      end else if (pos == tpid_pkg::POS_LEN_HI) begin
         frm_next.payload_length = {item.rx_byte, 8'h00};
      end else if (pos == tpid_pkg::POS_LEN_LO) begin
         frm_next.payload_length = {frm.payload_length[15:8], item.rx_byte};
         // length mismatch outranks unknown type
         if ((frm.frame_error == tpid_pkg::STATUS_OK ||
              frm.frame_error == tpid_pkg::STATUS_BAD_TYPE) &&
             (item.frame_len < tpid_pkg::HDR_BYTES +
                               tpid_pkg::FLEN_W'(frm_next.payload_length))) begin
            frm_next.frame_error = tpid_pkg::STATUS_LEN_MISS;
         end
      end else if (frm.frame_error == tpid_pkg::STATUS_OK && pos < payload_end) begin
         if (cur_addr < ADDR_LIMIT) begin
            res.write_valid = 1'b1;
            res.plane_sel   = frm.frame_plane;
            res.write_addr  = tpid_pkg::WADDR_W'(cur_addr);
            res.write_data  = item.rx_byte;
            if (frm.frame_plane == tpid_pkg::PLANE_MONO) begin
               mono_addr_next = cur_addr_inc;
            end else begin
               red_addr_next = cur_addr_inc;
            end
         end
      end

      if (item.frame_last) begin
         status = (pos < tpid_pkg::POS_LEN_LO) ? tpid_pkg::STATUS_SHORT
                                               : frm_next.frame_error;
         if (status == tpid_pkg::STATUS_OK && frm_next.frame_end_flag) begin
            res.image_done = 1'b1;
            red_addr_next  = '0;
            mono_addr_next = '0;
         end
         frm_next.byte_position = '0;
      end else if (pos != tpid_pkg::POS_MAX) begin
         frm_next.byte_position = pos + tpid_pkg::FLEN_W'(1);
      end

      res.frame_status = status;
   end

endmodule

// ===== hw/rtl/two_plane_image_packet_deframer.sv =====
// Each item is registered in the input stage, then its result in the result register.
// One item per cycle, rsp_ready permitting; frame state and plane addresses update in one pass.
// The input stage takes a new item when it is empty or its item moves on to the result register.
// Reset (synchronous, active high) empties both stages, zeroes the frame state and
// plane addresses, and loads the register defaults.
module two_plane_image_packet_deframer #(
   parameter int PLANE_BYTES = tpid_pkg::PLANE_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   input  logic [16:0]                     req_frame_len,
   input  logic                            req_frame_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_write_valid,
   output logic                            rsp_plane_sel,
   output logic [14:0]                     rsp_write_addr,
   output logic [7:0]                      rsp_write_data,
   output logic                            rsp_image_done,
   output logic [2:0]                      rsp_frame_status,
   input  logic                            csr_we,
   input  logic [tpid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                      csr_wdata
);

   localparam int AW = $clog2(PLANE_BYTES + 1);

   tpid_pkg::cfg_type    cfg_ff;
   tpid_pkg::item_type   item_ff, item_in;
   logic                 in_valid_ff, in_valid_in;
   tpid_pkg::frame_type  frm_ff, frm_in;
   logic [AW-1:0]        red_addr_ff, red_addr_in;
   logic [AW-1:0]        mono_addr_ff, mono_addr_in;
   tpid_pkg::result_type res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         item_in     = '{rx_byte: req_rx_byte, frame_len: req_frame_len,
                         frame_last: req_frame_last};
      end
   end

   tpid_frame_step #(
      .PLANE_BYTES (PLANE_BYTES)
   ) u_step (
      .cfg            (cfg_ff),
      .item           (item_ff),
      .frm            (frm_ff),
      .red_addr       (red_addr_ff),
      .mono_addr      (mono_addr_ff),
      .frm_next       (frm_in),
      .red_addr_next  (red_addr_in),
      .mono_addr_next (mono_addr_in),
      .res            (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value     <= tpid_pkg::SYNC_DEFAULT;
         cfg_ff.end_marker     <= tpid_pkg::END_MARK_DEFAULT;
         cfg_ff.red_type_code  <= tpid_pkg::RED_TYPE_DEFAULT;
         cfg_ff.mono_type_code <= tpid_pkg::MONO_TYPE_DEFAULT;
      end else if (csr_we) begin
         unique case (csr_index)
            tpid_pkg::CSR_SYNC:      cfg_ff.sync_value     <= csr_wdata;
            tpid_pkg::CSR_END_MARK:  cfg_ff.end_marker     <= csr_wdata;
            tpid_pkg::CSR_RED_TYPE:  cfg_ff.red_type_code  <= csr_wdata;
            tpid_pkg::CSR_MONO_TYPE: cfg_ff.mono_type_code <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         frm_ff       <= '0;
         red_addr_ff  <= '0;
         mono_addr_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            frm_ff       <= frm_in;
            red_addr_ff  <= red_addr_in;
            mono_addr_ff <= mono_addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_valid  = res_ff.write_valid;
   assign rsp_plane_sel    = res_ff.plane_sel;
   assign rsp_write_addr   = res_ff.write_addr;
   assign rsp_write_data   = res_ff.write_data;
   assign rsp_image_done   = res_ff.image_done;
   assign rsp_frame_status = res_ff.frame_status;

endmodule

// ===== hw/rtl/tpid_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
module tpid_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_write_valid,
   input logic                           rsp_plane_sel,
   input logic [14:0]                    rsp_write_addr,
   input logic [7:0]                     rsp_write_data,
   input logic                           rsp_image_done,
   input logic [2:0]                     rsp_frame_status
);

   // result item holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped before accept");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   // only ok frames store bytes
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> rsp_frame_status == tpid_pkg::STATUS_OK)
      else $error("write with error status");

   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |-> rsp_frame_status == tpid_pkg::STATUS_OK)
      else $error("image done on bad frame");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_valid |->
         !rsp_plane_sel && rsp_write_addr == 15'd0 && rsp_write_data == 8'd0)
      else $error("write fields not cleared without write");

endmodule

bind two_plane_image_packet_deframer tpid_checker u_tpid_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the two-plane image packet deframer: directed frames, random traffic.
module tb_top;
   import tpid_pkg::*;

   localparam int PLANE_BYTES   = PLANE_BYTES_DEFAULT;
   localparam int DIRECTED_ROWS = 25;
   localparam int HOLD_CYCLES   = 60;

   localparam result_type NO_RESULT = '0;

   typedef struct packed {
      logic [7:0]  rx;
      logic [16:0] flen;
      logic        last;
      logic        fixed;   // 1: want column is the expected result, else use the predictor
      result_type  want;
   } dir_row_type;

   // Default registers after reset: sync AA, end marker FF, red 14, mono 25.
   localparam dir_row_type DIRECTED [DIRECTED_ROWS] = '{
      // too short by length tag, last arrives on byte 1
      '{8'hAA, 17'd0,     1'b0, 1'b1, NO_RESULT},
      '{8'h00, 17'd0,     1'b1, 1'b1, '{1'b0, 1'b0, 15'd0, 8'h00, 1'b0, STATUS_SHORT}},
      // wrong sync byte, longest length tag
      '{8'h55, 17'd65540, 1'b0, 1'b1, NO_RESULT},
      '{8'hFF, 17'd65540, 1'b0, 1'b0, NO_RESULT},
      '{8'h14, 17'd65540, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 17'd65540, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 17'd65540, 1'b1, 1'b1, '{1'b0, 1'b0, 15'd0, 8'h00, 1'b0, STATUS_BAD_SYNC}},
      // good red frame with end marker: one byte stored, image done
      '{8'hAA, 17'd6,     1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 17'd6,     1'b0, 1'b0, NO_RESULT},
      '{8'h14, 17'd6,     1'b0, 1'b0, NO_RESULT},
      '{8'h00, 17'd6,     1'b0, 1'b0, NO_RESULT},
      '{8'h01, 17'd6,     1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 17'd6,     1'b1, 1'b1, '{1'b1, PLANE_RED, 15'd0, 8'hFF, 1'b1, STATUS_OK}},
      // unknown type and length mismatch together: mismatch wins, byte 4 tag decides
      '{8'hAA, 17'd100,   1'b0, 1'b0, NO_RESULT},
      '{8'h00, 17'd100,   1'b0, 1'b0, NO_RESULT},
      '{8'h77, 17'd100,   1'b0, 1'b0, NO_RESULT},
      '{8'h00, 17'd100,   1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 17'd20,    1'b1, 1'b1, '{1'b0, 1'b0, 15'd0, 8'h00, 1'b0, STATUS_LEN_MISS}},
      // mono frame, no end marker, one extra byte that is ignored
      '{8'hAA, 17'd7,     1'b0, 1'b0, NO_RESULT},
      '{8'h00, 17'd7,     1'b0, 1'b0, NO_RESULT},
      '{8'h25, 17'd7,     1'b0, 1'b0, NO_RESULT},
      '{8'h00, 17'd7,     1'b0, 1'b0, NO_RESULT},
      '{8'h01, 17'd7,     1'b0, 1'b0, NO_RESULT},
      '{8'h00, 17'd7,     1'b0, 1'b1, '{1'b1, PLANE_MONO, 15'd0, 8'h00, 1'b0, STATUS_OK}},
      '{8'h3C, 17'd7,     1'b1, 1'b1, NO_RESULT}
   };

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_rx_byte    = '0;
   logic [16:0]          req_frame_len  = '0;
   logic                 req_frame_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic                 rsp_write_valid;
   logic                 rsp_plane_sel;
   logic [14:0]          rsp_write_addr;
   logic [7:0]           rsp_write_data;
   logic                 rsp_image_done;
   logic [2:0]           rsp_frame_status;
   logic                 csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_SYNC;
   logic [7:0]           csr_wdata      = '0;

   // predictor state
   cfg_type     csr_shadow;
   logic [16:0] frm_pos;
   logic        frm_end;
   logic        frm_plane;
   logic [15:0] frm_plen;
   logic [2:0]  frm_err;
   logic [15:0] red_addr;
   logic [15:0] mono_addr;

   result_type  predicted_rsp[$];

   int send_idle_pct = 23;
   int recv_idle_pct = 84;
   int rsp_hold      = 0;
   int mismatches    = 0;
   int items_sent    = 0;
   int frames_sent   = 0;
   int rsp_checked   = 0;
   int plane_writes  = 0;
   int images_done   = 0;
   int bad_frames    = 0;

   two_plane_image_packet_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_frame_len    (req_frame_len),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_plane_sel    (rsp_plane_sel),
      .rsp_write_addr   (rsp_write_addr),
      .rsp_write_data   (rsp_write_data),
      .rsp_image_done   (rsp_image_done),
      .rsp_frame_status (rsp_frame_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // Works out the write and status for one received byte and advances the frame state.
   function automatic result_type deframe_byte(input logic [7:0] rx, input logic [16:0] flen,
                                               input logic last);
      result_type  r;
      logic [16:0] pos;
      r   = '0;
      pos = frm_pos;
      if (pos == POS_SYNC) begin
         frm_end   = 1'b0;
         frm_plane = PLANE_RED;
         frm_plen  = '0;
         if (flen < HDR_BYTES) frm_err = STATUS_SHORT;
         else if (rx != csr_shadow.sync_value) frm_err = STATUS_BAD_SYNC;
         else frm_err = STATUS_OK;
      end else if (pos == POS_END_MARK) begin
         frm_end = (rx == csr_shadow.end_marker);
      end else if (pos == POS_TYPE) begin
         if (frm_err == STATUS_OK) begin
            if (rx == csr_shadow.red_type_code) frm_plane = PLANE_RED;
            else if (rx == csr_shadow.mono_type_code) frm_plane = PLANE_MONO;
            else frm_err = STATUS_BAD_TYPE;
         end
      end else if (pos == POS_LEN_HI) begin
         frm_plen = {rx, 8'h00};
      end else if (pos == POS_LEN_LO) begin
         frm_plen[7:0] = rx;
         if ((frm_err == STATUS_OK || frm_err == STATUS_BAD_TYPE) &&
             flen < HDR_BYTES + 17'(frm_plen))
            frm_err = STATUS_LEN_MISS;
      end else if (frm_err == STATUS_OK && pos < HDR_BYTES + 17'(frm_plen)) begin
         // plane addresses stop at the plane size, later payload is dropped
         if (frm_plane == PLANE_MONO && mono_addr < PLANE_BYTES) begin
            r.write_valid = 1'b1;
            r.plane_sel   = PLANE_MONO;
            r.write_addr  = mono_addr[14:0];
            r.write_data  = rx;
            mono_addr     = mono_addr + 16'd1;
         end else if (frm_plane == PLANE_RED && red_addr < PLANE_BYTES) begin
            r.write_valid = 1'b1;
            r.plane_sel   = PLANE_RED;
            r.write_addr  = red_addr[14:0];
            r.write_data  = rx;
            red_addr      = red_addr + 16'd1;
         end
      end
      if (last) begin
         r.frame_status = (pos < POS_LEN_LO) ? STATUS_SHORT : frm_err;
         if (r.frame_status == STATUS_OK && frm_end) begin
            r.image_done = 1'b1;
            red_addr     = '0;
            mono_addr    = '0;
         end
         frm_pos = '0;
      end else if (pos != POS_MAX) begin
         frm_pos = pos + 17'd1;
      end
      return r;
   endfunction

   function automatic logic [7:0] other_byte(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] v;
      do v = 8'($urandom_range(255)); while (v == a || v == b);
      return v;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t, result %0d: %s", $time, rsp_checked, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Offers one item, waits for acceptance and queues what it should produce.
   task automatic send_byte(input logic [7:0] rx, input logic [16:0] flen, input logic last,
                            input logic fixed, input result_type want);
      result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_rx_byte    <= rx;
      req_frame_len  <= flen;
      req_frame_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = deframe_byte(rx, flen, last);
      predicted_rsp.push_back(fixed ? want : predicted);
      items_sent++;
      if (predicted.write_valid) plane_writes++;
      if (predicted.image_done) images_done++;
      if (last) begin
         frames_sent++;
         if (predicted.frame_status != STATUS_OK) bad_frames++;
      end
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] sync_b, input logic [7:0] end_b,
                             input logic [7:0] type_b, input logic [15:0] plen,
                             input int nbytes, input logic [16:0] flen,
                             input logic [16:0] flen_at_len);
      logic [7:0] b;
      for (int i = 0; i < nbytes; i++) begin
         case (i)
            POS_SYNC:     b = sync_b;
            POS_END_MARK: b = end_b;
            POS_TYPE:     b = type_b;
            POS_LEN_HI:   b = plen[15:8];
            POS_LEN_LO:   b = plen[7:0];
            default:      b = 8'($urandom_range(255));
         endcase
         send_byte(b, (i == POS_LEN_LO) ? flen_at_len : flen, i == nbytes - 1, 1'b0,
                   NO_RESULT);
      end
   endtask

   task automatic send_random_frame();
      int unsigned kind, plen, nbytes;
      logic [7:0]  sync_b, end_b, type_b;
      logic [16:0] flen, flen_at_len;
      kind   = $urandom_range(99);
      plen   = ($urandom_range(7) == 0) ? $urandom_range(48) : $urandom_range(6);
      nbytes = 5 + plen + $urandom_range(2);
      sync_b = csr_shadow.sync_value;
      end_b  = ($urandom_range(2) == 0) ? csr_shadow.end_marker : 8'($urandom_range(255));
      type_b = $urandom_range(1) ? csr_shadow.mono_type_code : csr_shadow.red_type_code;
      flen   = ($urandom_range(7) == 0) ? 17'($urandom_range(65540, 5 + plen)) : 17'(nbytes);
      flen_at_len = flen;
      if (kind >= 88) begin
         // noise, closed by a last byte so the next frame starts clean
         nbytes = $urandom_range(8, 1);
         for (int i = 0; i < nbytes; i++)
            send_byte(8'($urandom_range(255)), 17'($urandom_range(65540)),
                      i == nbytes - 1 || $urandom_range(3) == 0, 1'b0, NO_RESULT);
      end else begin
         if (kind >= 82) begin
            type_b = other_byte(csr_shadow.red_type_code, csr_shadow.mono_type_code);
         end else if (kind >= 75) begin
            plen        = $urandom_range(40, 1);
            nbytes      = $urandom_range(5 + plen, 5);
            flen        = $urandom_range(1) ? 17'($urandom_range(65540, 5)) : 17'(nbytes);
            flen_at_len = 17'($urandom_range(4 + plen));
            if ($urandom_range(1))
               type_b = other_byte(csr_shadow.red_type_code, csr_shadow.mono_type_code);
         end else if (kind >= 68) begin
            sync_b = other_byte(sync_b, sync_b);
         end else if (kind >= 60) begin
            if ($urandom_range(1)) nbytes = $urandom_range(4, 1);
            else flen = 17'($urandom_range(4));
         end
         send_frame(sync_b, end_b, type_b, 16'(plen), nbytes, flen, flen_at_len);
      end
   endtask

   task automatic run_frames(input int n_items);
      int first;
      first = items_sent;
      while (items_sent - first < n_items) send_random_frame();
   endtask

   // Stops offering and waits for every queued result, plus the pipeline latency.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (predicted_rsp.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_SYNC;
      csr_wdata <= c.sync_value;
      @(negedge clock);
      csr_index <= CSR_END_MARK;
      csr_wdata <= c.end_marker;
      @(negedge clock);
      csr_index <= CSR_RED_TYPE;
      csr_wdata <= c.red_type_code;
      @(negedge clock);
      csr_index <= CSR_MONO_TYPE;
      csr_wdata <= c.mono_type_code;
      @(negedge clock);
      csr_we     <= 1'b0;
      csr_shadow  = c;
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold   = rsp_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_rsp.size() == 0) begin
            note_mismatch("result arrived with nothing expected");
         end else begin
            want = predicted_rsp.pop_front();
            check_field("write_valid", 16'(rsp_write_valid), 16'(want.write_valid));
            check_field("plane_sel", 16'(rsp_plane_sel), 16'(want.plane_sel));
            check_field("write_addr", 16'(rsp_write_addr), 16'(want.write_addr));
            check_field("write_data", 16'(rsp_write_data), 16'(want.write_data));
            check_field("image_done", 16'(rsp_image_done), 16'(want.image_done));
            check_field("frame_status", 16'(rsp_frame_status), 16'(want.frame_status));
         end
         rsp_checked++;
      end
   end

   initial begin : stimulus
      cfg_type next_cfg;
      csr_shadow = '{SYNC_DEFAULT, END_MARK_DEFAULT, RED_TYPE_DEFAULT, MONO_TYPE_DEFAULT};
      frm_pos    = '0;
      frm_end    = 1'b0;
      frm_plane  = PLANE_RED;
      frm_plen   = '0;
      frm_err    = STATUS_OK;
      red_addr   = '0;
      mono_addr  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_byte(DIRECTED[i].rx, DIRECTED[i].flen, DIRECTED[i].last, DIRECTED[i].fixed,
                   DIRECTED[i].want);
      run_frames(150);

      // extremes, with both type codes equal so red must win
      wait_idle();
      load_config('{8'h00, 8'h00, 8'hFF, 8'hFF});
      send_idle_pct = 84;
      recv_idle_pct = 23;
      run_frames(150);

      wait_idle();
      next_cfg = '{8'hFF, 8'($urandom_range(255)), 8'h00, 8'($urandom_range(255, 1))};
      load_config(next_cfg);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_frames(80);
      // receiver stalls while a frame keeps coming, so the input side backs up
      rsp_hold = HOLD_CYCLES;
      send_frame(csr_shadow.sync_value, csr_shadow.end_marker, csr_shadow.red_type_code,
                 16'd20, 25, 17'd25, 17'd25);
      wait_idle();
      run_frames(80);

      wait_idle();
      next_cfg = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'h00};
      next_cfg.mono_type_code = ~next_cfg.red_type_code;
      load_config(next_cfg);
      // red frame without end marker, addresses keep running into the next frames
      send_frame(csr_shadow.sync_value, ~csr_shadow.end_marker, csr_shadow.red_type_code,
                 16'd4, 9, 17'd9, 17'd9);
      run_frames(30);
      wait_idle();

      $display("Run covered %0d items in %0d frames (%0d rejected) under four register settings",
               items_sent, frames_sent, bad_frames);
      $display("%0d results checked: %0d plane writes, %0d images completed, %0d mismatches",
               rsp_checked, plane_writes, images_done, mismatches);
      if (mismatches == 0 && predicted_rsp.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timeout: stimulus or results did not complete");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
